[sv/tama_pkg.sv]
package tama_pkg;

  // Width of the window length register and of the sample count that is bounded by it.
  localparam int LEN_BITS = 11;
  localparam int NUM_AXES = 3;

  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS = 3;

  // Register index as seen in paddr[2] (word addressing).
  localparam logic IDX_WINDOW_LENGTH = 1'b0;
  localparam logic [LEN_BITS-1:0] WINDOW_LENGTH_RESET = 11'd1;

  typedef struct packed {
    logic clear;
    logic read;
    logic update;
    logic was_full;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

endpackage

[sv/tama_in_if.sv]
interface tama_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

[sv/tama_out_if.sv]
interface tama_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic signed [SAMPLE_BITS-1:0] raw_y;
  logic signed [SAMPLE_BITS-1:0] raw_z;
  logic signed [SAMPLE_BITS-1:0] mean_x;
  logic signed [SAMPLE_BITS-1:0] mean_y;
  logic signed [SAMPLE_BITS-1:0] mean_z;
  logic                          window_full;

  modport source (output valid, output raw_x, output raw_y, output raw_z,
                  output mean_x, output mean_y, output mean_z, output window_full,
                  input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z,
                input mean_x, input mean_y, input mean_z, input window_full,
                output ready);
endinterface

[sv/tama_ram.sv]
module tama_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/tama_lane.sv]
module tama_lane import tama_pkg::*; #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctrl_t                    ctrl_i,
  input  logic [$clog2(MAX_WINDOW)-1:0] addr_i,
  input  logic [LEN_BITS-1:0]           len_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] mean_o
);

  localparam int SUM_BITS = SAMPLE_BITS + LEN_BITS;

  logic [SAMPLE_BITS-1:0]     old_sample;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic signed [SUM_BITS-1:0] sample_ext, old_ext;
  logic [SUM_BITS-1:0]        quo_q;
  logic [LEN_BITS-1:0]        rem_q;
  logic                       neg_q;
  logic [LEN_BITS:0]          rem_sh;
  logic [LEN_BITS+1:0]        diff;
  logic [SUM_BITS-1:0]        quo_signed;

  // The old sample is read in the accept cycle and replaced in the update cycle.
  tama_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.update),
    .waddr_i (addr_i),
    .wdata_i (sample_i),
    .re_i    (ctrl_i.read),
    .raddr_i (addr_i),
    .rdata_o (old_sample)
  );

  assign sample_ext = {{LEN_BITS{sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign old_ext    = ctrl_i.was_full ?
                      {{LEN_BITS{old_sample[SAMPLE_BITS-1]}}, old_sample} : '0;
  assign sum_d      = sum_q + sample_ext - old_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clear) begin
      sum_q <= '0;
    end else if (ctrl_i.update) begin
      sum_q <= sum_d;
    end
  end

  // Restoring divider on the magnitude of the sum, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[SUM_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, len_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      neg_q <= sum_q[SUM_BITS-1];
      quo_q <= sum_q[SUM_BITS-1] ? (~sum_q + 1'b1) : sum_q;
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      if (diff[LEN_BITS+1]) begin
        rem_q <= rem_sh[LEN_BITS-1:0];
        quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
      end else begin
        rem_q <= diff[LEN_BITS-1:0];
        quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
      end
    end
  end

  // Negating the magnitude gives truncation toward zero.
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign mean_o     = quo_signed[SAMPLE_BITS-1:0];

endmodule

[sv/tama_merge.sv]
module tama_merge import tama_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          full_i,
  input  logic signed [SAMPLE_BITS-1:0] raw_i  [NUM_AXES],
  input  logic signed [SAMPLE_BITS-1:0] mean_i [NUM_AXES],
  output logic                          free_o,
  tama_out_if.source                    out_o
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] raw_q  [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] mean_q [NUM_AXES];
  logic                          full_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Means are forced to zero until the window has filled.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      full_q <= full_i;
      for (int a = 0; a < NUM_AXES; a++) begin
        raw_q[a]  <= raw_i[a];
        mean_q[a] <= full_i ? mean_i[a] : '0;
      end
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.raw_x       = raw_q[0];
  assign out_o.raw_y       = raw_q[1];
  assign out_o.raw_z       = raw_q[2];
  assign out_o.mean_x      = mean_q[0];
  assign out_o.mean_y      = mean_q[1];
  assign out_o.mean_z      = mean_q[2];
  assign out_o.window_full = full_q;

endmodule

[sv/three_axis_moving_average.sv]
// Boxcar moving average over the last N three-axis samples, N being the low LEN_BITS
// bits of window_length (0 acts as 1, values above min(MAX_WINDOW, 2047) act as
// that bound). Every accepted sample yields one result: the raw sample, the per-axis
// mean truncated toward zero, and window_full once N samples have arrived (means
// read 0 until then). Writing window_length empties the window. Each axis has its
// own lane with a history RAM, a running sum and a restoring divider; the three
// lanes run in lockstep. A sample goes through the update state and, once the window
// is full, the load and divide states, the divider making one quotient bit per cycle.
// The result sits in an output register, so the next sample is taken while it waits.
module three_axis_moving_average import tama_pkg::*; #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_BITS-1:0]    paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  tama_in_if.sink                  in_i,
  tama_out_if.source               out_o
);

  localparam int AW       = $clog2(MAX_WINDOW);
  localparam int SUM_BITS = SAMPLE_BITS + LEN_BITS;
  localparam int CNTW     = $clog2(SUM_BITS);
  localparam int CMPW     = ((AW > LEN_BITS) ? AW : LEN_BITS) + 1;
  localparam logic [LEN_BITS-1:0] MAX_LEN =
    (MAX_WINDOW > 2047) ? LEN_BITS'(2047) : LEN_BITS'(MAX_WINDOW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_LOAD,
    S_DIVIDE,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [LEN_BITS-1:0]           window_length_q;
  logic [LEN_BITS-1:0]           len_q;
  logic [AW-1:0]                 wp_q, wp_d;
  logic [LEN_BITS-1:0]           seen_q, seen_d;
  logic [CNTW-1:0]               cnt_q;
  logic                          full_q;
  logic signed [SAMPLE_BITS-1:0] sample_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] mean     [NUM_AXES];

  logic                accept;
  logic                cfg_we;
  logic [LEN_BITS-1:0] cfg_len;
  logic [LEN_BITS-1:0] len_d;
  logic [CMPW-1:0]     wp_inc;
  logic                was_full;
  logic                merge_free;
  logic                merge_load;
  lane_ctrl_t          lane_ctrl;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // Configuration port.
  assign pready  = 1'b1;
  assign prdata  = {{(APB_DATA_BITS-LEN_BITS){1'b0}}, window_length_q};
  assign cfg_we  = psel && penable && pwrite && (paddr[2] == IDX_WINDOW_LENGTH);
  assign cfg_len = pwdata[LEN_BITS-1:0];
  assign len_d   = (cfg_len == '0) ? LEN_BITS'(1) :
                   (cfg_len > MAX_LEN) ? MAX_LEN : cfg_len;

  // Window bookkeeping shared by all lanes.
  assign wp_inc   = CMPW'(wp_q) + CMPW'(1);
  assign wp_d     = (wp_inc >= CMPW'(len_q)) ? '0 : wp_inc[AW-1:0];
  assign seen_d   = (seen_q < len_q) ? seen_q + LEN_BITS'(1) : seen_q;
  assign was_full = (seen_q >= len_q);

  assign merge_load = (state_q == S_DONE) && merge_free;

  always_comb begin
    lane_ctrl          = '0;
    lane_ctrl.clear    = cfg_we;
    lane_ctrl.read     = accept;
    lane_ctrl.update   = (state_q == S_UPDATE);
    lane_ctrl.was_full = was_full;
    lane_ctrl.div_load = (state_q == S_LOAD);
    lane_ctrl.div_step = (state_q == S_DIVIDE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      window_length_q <= WINDOW_LENGTH_RESET;
      len_q           <= WINDOW_LENGTH_RESET;
      wp_q            <= '0;
      seen_q          <= '0;
      cnt_q           <= '0;
      full_q          <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length_q <= cfg_len;
        len_q           <= len_d;
        wp_q            <= '0;
        seen_q          <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          wp_q   <= wp_d;
          seen_q <= seen_d;
          full_q <= (seen_d >= len_q);
          state_q <= (seen_d >= len_q) ? S_LOAD : S_DONE;
        end
        S_LOAD: begin
          cnt_q   <= '0;
          state_q <= S_DIVIDE;
        end
        S_DIVIDE: begin
          cnt_q <= cnt_q + CNTW'(1);
          if (cnt_q == CNTW'(SUM_BITS - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (merge_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q[0] <= in_i.sample_x;
      sample_q[1] <= in_i.sample_y;
      sample_q[2] <= in_i.sample_z;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    tama_lane #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .addr_i   (wp_q),
      .len_i    (len_q),
      .sample_i (sample_q[a]),
      .mean_o   (mean[a])
    );
  end

  tama_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (merge_load),
    .full_i (full_q),
    .raw_i  (sample_q),
    .mean_i (mean),
    .free_o (merge_free),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_wp_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(wp_q) < CMPW'(len_q))
    else $error("write position outside the window");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= len_q)
    else $error("sample count beyond the window length");

  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) && (len_q <= MAX_LEN))
    else $error("effective window length out of range");

  a_accept_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_UPDATE))
    else $error("accepted transaction did not reach the update cycle");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE) |-> (32'(cnt_q) < SUM_BITS))
    else $error("divider ran past its last step");
`endif

endmodule
